@@ src/lfn_pkg.sv @@
// Shared types, constants and entry packing helper for the LFN entry unit.
`default_nettype none

package lfn_pkg;

    localparam int NAME_UNITS_DEF = 256;
    localparam int SLICE_UNITS    = 13;
    localparam int MAX_ORDER      = 20;
    localparam int POS_W          = 12;   // holds (191-1)*13+13
    localparam int STEP_W         = 4;

    localparam logic [15:0] FILLER    = 16'hFFFF;
    localparam logic [7:0]  LAST_FLAG = 8'h40;
    localparam logic [7:0]  LFN_ATTR  = 8'h0F;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_UNPACK = 2'd2;
    localparam logic [1:0] ACT_PACK   = 2'd3;

    // byte offsets of the 13 name units inside a 32-byte entry
    localparam logic [4:0] CHAR_POS [SLICE_UNITS] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
        5'd28, 5'd30
    };

    typedef logic [15:0] unit_t;
    typedef logic [SLICE_UNITS-1:0][15:0] slice_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_index;
        logic [15:0] char_value;
        logic [63:0] entry_word0;
        logic [63:0] entry_word1;
        logic [63:0] entry_word2;
        logic [63:0] entry_word3;
        logic [7:0]  sequence_order;
        logic [7:0]  short_name_sum;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [15:0] char_out;
        logic [63:0] packed_word0;
        logic [63:0] packed_word1;
        logic [63:0] packed_word2;
        logic [63:0] packed_word3;
    } rsp_t;

    typedef struct packed {
        logic store;      // unit is at or before the first zero
        logic bad;        // unit after the terminator is not a filler
        logic zero_thru;  // a zero seen at or before this lane
    } lane_t;

    typedef struct packed {
        logic [STEP_W-1:0] count;
        logic              filler_err;
        logic              has_zero;
    } merge_t;

    function automatic logic [255:0] pack_entry(input logic [7:0] order,
                                                input logic [7:0] sum,
                                                input slice_t slots);
        logic [255:0] e;
        begin
            e = '0;
            e[7:0]       = order;
            e[11*8 +: 8] = LFN_ATTR;
            e[13*8 +: 8] = sum;
            for (int s = 0; s < SLICE_UNITS; s++)
            begin
                e[8*CHAR_POS[s] +: 16] = slots[s];
            end
            return e;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/lfn_buf.sv @@
// Single-port name buffer with registered read data.
`default_nettype none

module lfn_buf
    import lfn_pkg::*;
#(
    parameter int DEPTH = NAME_UNITS_DEF,
    parameter int AW    = 8
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire unit_t         wdata,
    output unit_t              rdata
);

    unit_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (32'(addr) < DEPTH)
            begin
                mem[addr] <= wdata;
            end
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ src/lfn_lane.sv @@
// One name-unit lane of the unpack check: terminator tracking and filler test.
`default_nettype none

module lfn_lane
    import lfn_pkg::*;
(
    input  wire unit_t  unit,
    input  wire logic   zero_before,
    output lane_t       info
);

    always_comb
    begin
        info.store     = !zero_before;
        info.bad       = zero_before && (unit != FILLER);
        info.zero_thru = zero_before || (unit == 16'd0);
    end

endmodule

`default_nettype wire

@@ src/lfn_merge.sv @@
// Combines lane results: units to store, filler error, terminator present.
`default_nettype none

module lfn_merge
    import lfn_pkg::*;
(
    input  wire lane_t [SLICE_UNITS-1:0] lanes,
    output merge_t                       result
);

    logic [SLICE_UNITS-1:0] store_vec;
    logic [SLICE_UNITS-1:0] bad_vec;

    always_comb
    begin
        for (int s = 0; s < SLICE_UNITS; s++)
        begin
            store_vec[s] = lanes[s].store;
            bad_vec[s]   = lanes[s].bad;
        end
        result.count      = STEP_W'($countones(store_vec));
        result.filler_err = |bad_vec;
        result.has_zero   = lanes[SLICE_UNITS-1].zero_thru;
    end

endmodule

`default_nettype wire

@@ src/lfn_entry_pack_unpack.sv @@
// Top level: LFN long-name buffer with char access and entry unpack/pack.
// One item at a time. The buffer is a single-port RAM, one unit per cycle.
// Unpack writes the units stored, and an appended terminator is written in
// the closing check cycle; pack makes 14 buffer reads, the 13 slice units
// and the unit after the slice.
// A rejected unpack or pack goes straight from the request check to the result.
// Thirteen lanes check an entry's units in parallel before the store loop.
// The next item is taken while a result waits on the output register.
`default_nettype none

module lfn_entry_pack_unpack
    import lfn_pkg::*;
#(
    parameter int NAME_UNITS = NAME_UNITS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = (NAME_UNITS > 1) ? $clog2(NAME_UNITS) : 1;
    localparam logic [POS_W-1:0] NU_POS = POS_W'(NAME_UNITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_RDW  = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] n_reg, n_next;
    logic              ferr_reg, ferr_next;
    logic              app_reg, app_next;
    logic              done_reg, done_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;
    unit_t             char_reg, char_next;
    slice_t            slot_reg, slot_next;
    logic              pv_reg, pv_next;
    logic [STEP_W-1:0] pstep_reg, pstep_next;
    logic              pok_reg, pok_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    unit_t             mem_wdata;
    unit_t             mem_rdata;

    logic [255:0]      entry;
    logic [7:0]        ord_byte;
    logic [7:0]        ord;
    slice_t            lane_unit;
    lane_t [SLICE_UNITS-1:0] lane_info;
    logic [SLICE_UNITS:0]    zchain;
    merge_t            mrg;
    logic [POS_W-1:0]  unpk_base;
    logic [POS_W-1:0]  pack_base;
    logic [POS_W-1:0]  pos;
    logic              pos_ok;
    logic [POS_W-1:0]  idx_pos;
    logic              idx_ok;
    unit_t             unit_sel;
    unit_t             rd_unit;
    logic [255:0]      words;

    lfn_buf #(
        .DEPTH (NAME_UNITS),
        .AW    (AW)
    ) u_buf (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign entry    = {req_reg.entry_word3, req_reg.entry_word2,
                       req_reg.entry_word1, req_reg.entry_word0};
    assign ord_byte = entry[7:0];
    assign ord      = ord_byte & ~LAST_FLAG;
    assign zchain[0] = 1'b0;

    for (genvar s = 0; s < SLICE_UNITS; s++)
    begin : g_lane
        assign lane_unit[s] = entry[8*CHAR_POS[s] +: 16];
        lfn_lane u_lane (
            .unit        (lane_unit[s]),
            .zero_before (zchain[s]),
            .info        (lane_info[s])
        );
        assign zchain[s+1] = lane_info[s].zero_thru;
    end

    lfn_merge u_merge (
        .lanes  (lane_info),
        .result (mrg)
    );

    assign unpk_base = (POS_W'(ord) - POS_W'(1)) * POS_W'(SLICE_UNITS);
    assign pack_base = (POS_W'(req_reg.sequence_order) - POS_W'(1)) * POS_W'(SLICE_UNITS);
    assign pos       = base_reg + POS_W'(step_reg);
    assign pos_ok    = pos < NU_POS;
    assign idx_pos   = POS_W'(req_reg.char_index);
    assign idx_ok    = idx_pos < NU_POS;
    assign unit_sel  = (step_reg < STEP_W'(SLICE_UNITS)) ? lane_unit[step_reg] : '0;
    assign rd_unit   = pok_reg ? mem_rdata : '0;

    assign words = pack_entry(req_reg.sequence_order | (last_reg ? LAST_FLAG : 8'h00),
                              req_reg.short_name_sum, slot_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        ferr_next      = ferr_reg;
        app_next       = app_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        char_next      = char_reg;
        slot_next      = slot_reg;
        pv_next        = 1'b0;
        pstep_next     = step_reg;
        pok_next       = pos_ok;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_addr       = pos[AW-1:0];
        mem_wdata      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    status_next = 1'b0;
                    char_next   = '0;
                    done_next   = 1'b0;
                    last_next   = 1'b0;
                    step_next   = '0;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                unique case (req_reg.action)
                    ACT_WRITE:
                    begin
                        mem_we     = idx_ok;
                        mem_addr   = idx_pos[AW-1:0];
                        mem_wdata  = req_reg.char_value;
                        state_next = ST_FIN;
                    end
                    ACT_READ:
                    begin
                        mem_addr   = idx_pos[AW-1:0];
                        state_next = ST_RDW;
                    end
                    ACT_UNPACK:
                    begin
                        if (entry[26*8 +: 16] != 16'd0 || ord == 8'd0)
                        begin
                            status_next = 1'b1;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            base_next  = unpk_base;
                            n_next     = mrg.count;
                            ferr_next  = mrg.filler_err;
                            app_next   = ((ord_byte & LAST_FLAG) != 8'h00) && !mrg.has_zero;
                            state_next = ST_RUN;
                        end
                    end
                    ACT_PACK:
                    begin
                        if (req_reg.sequence_order == 8'd0 ||
                            req_reg.sequence_order > 8'(MAX_ORDER))
                        begin
                            status_next = 1'b1;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            base_next  = pack_base;
                            state_next = ST_RUN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_RDW:
            begin
                char_next  = idx_ok ? mem_rdata : '0;
                state_next = ST_FIN;
            end
            ST_RUN:
            begin
                if (req_reg.action == ACT_UNPACK)
                begin
                    if (step_reg < n_reg)
                    begin
                        if (pos_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = unit_sel;
                            step_next = step_reg + STEP_W'(1);
                        end
                        else
                        begin
                            status_next = 1'b1;
                            state_next  = ST_FIN;
                        end
                    end
                    else
                    begin
                        // stores done: filler check, then optional terminator
                        if (ferr_reg)
                        begin
                            status_next = 1'b1;
                        end
                        else if (app_reg)
                        begin
                            mem_we      = pos_ok;
                            status_next = !pos_ok;
                        end
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    // pack: issue read of step, consume the read of step-1
                    if (step_reg < STEP_W'(SLICE_UNITS + 1))
                    begin
                        pv_next   = 1'b1;
                        step_next = step_reg + STEP_W'(1);
                    end
                    if (pv_reg)
                    begin
                        if (pstep_reg < STEP_W'(SLICE_UNITS))
                        begin
                            slot_next[pstep_reg] = done_reg ? FILLER : rd_unit;
                            if (rd_unit == 16'd0 || rd_unit == FILLER)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        else
                        begin
                            last_next  = done_reg || (rd_unit == 16'd0);
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status   = status_reg;
                    rsp_next.char_out = char_reg;
                    if (req_reg.action == ACT_PACK && !status_reg)
                    begin
                        rsp_next.packed_word0 = words[63:0];
                        rsp_next.packed_word1 = words[127:64];
                        rsp_next.packed_word2 = words[191:128];
                        rsp_next.packed_word3 = words[255:192];
                    end
                    else
                    begin
                        rsp_next.packed_word0 = '0;
                        rsp_next.packed_word1 = '0;
                        rsp_next.packed_word2 = '0;
                        rsp_next.packed_word3 = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pv_reg        <= pv_next;
            step_reg      <= step_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        base_reg   <= base_next;
        n_reg      <= n_next;
        ferr_reg   <= ferr_next;
        app_reg    <= app_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        char_reg   <= char_next;
        slot_reg   <= slot_next;
        pstep_reg  <= pstep_next;
        pok_reg    <= pok_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
